// ----- hw/rtl/rwgrf_pkg.sv -----
// Shared constants, types and helper functions of the gray-range filter.
package rwgrf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_MASK   = 31;
  localparam int RESULT_CAP = 16;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int MK_W   = 5;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int RING_W = $clog2(MAX_MASK + 1);
  localparam int ADDR_W = RING_W + COL_W;
  localparam int DEPTH  = (MAX_MASK + 1) * MAX_WIDTH;
  localparam int HALF_W = $clog2((MAX_MASK + 1) / 2);
  localparam int CRD_W  = FH_W + 2;
  localparam int CNT_W  = $clog2(RESULT_CAP + 1);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MASK_WIDTH   = 2'd2,
    CFG_MASK_HEIGHT  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_CHECK,
    CTL_BUSY
  } ctl_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_TAIL,
    ENG_DONE
  } eng_state_t;

  // Frame and window geometry after saturation and clamping.
  typedef struct packed {
    logic [FW_W-1:0]   w;
    logic [FH_W-1:0]   h;
    logic [COL_W-1:0]  wm1;
    logic [ROW_W-1:0]  hm1;
    logic [HALF_W-1:0] hw;
    logic [HALF_W-1:0] hh;
  } geom_t;

  // Reflect-101 mirroring of one coordinate into 0..n-1.
  function automatic logic [CRD_W-1:0] mirror(input logic signed [CRD_W-1:0] v,
                                               input logic [FH_W-1:0] n);
    logic signed [CRD_W-1:0] t;
    logic signed [CRD_W-1:0] nn;
    t  = v;
    nn = signed'(CRD_W'(n));
    if (t < 0) t = -t;
    if (t >= nn) t = (nn <<< 1) - signed'(CRD_W'(2)) - t;
    if (t < 0) t = '0;
    return t;
  endfunction

  // True when the last pixel of the window around (orow, ocol) has arrived.
  function automatic logic win_ready(input logic [ROW_W-1:0] orow,
                                     input logic [COL_W-1:0] ocol,
                                     input geom_t g,
                                     input logic [ROW_W-1:0] ir,
                                     input logic [COL_W-1:0] ic);
    logic [ROW_W:0] lr;
    logic [COL_W:0] lc;
    lr = {1'b0, orow} + (ROW_W + 1)'(g.hh);
    lc = {1'b0, ocol} + (COL_W + 1)'(g.hw);
    if (lr > {1'b0, g.hm1}) lr = {1'b0, g.hm1};
    if (lc > {1'b0, g.wm1}) lc = {1'b0, g.wm1};
    return (lr[ROW_W-1:0] < ir) || ((lr[ROW_W-1:0] == ir) && (lc[COL_W-1:0] <= ic));
  endfunction

endpackage

// ----- hw/rtl/rwgrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rwgrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rwgrf_scan.sv -----
// Window scanner: walks the window one store read per cycle and folds min and max.
module rwgrf_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  rwgrf_pkg::geom_t            geom,
  input  logic [rwgrf_pkg::ROW_W-1:0] orow,
  input  logic [rwgrf_pkg::COL_W-1:0] ocol,
  output logic                        rd_en,
  output logic [rwgrf_pkg::ADDR_W-1:0] rd_addr,
  input  logic [rwgrf_pkg::PIX_W-1:0] rd_data,
  output logic                        done,
  output logic                        busy,
  output logic [rwgrf_pkg::PIX_W-1:0] range_value
);
  import rwgrf_pkg::*;

  eng_state_t               state_r, state_nxt;
  logic signed [HALF_W:0]   dy_r, dy_nxt, dx_r, dx_nxt;
  logic signed [HALF_W:0]   hh_s, hw_s;
  logic                     rd_vld_r;
  logic [PIX_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CRD_W-1:0]         y, x;
  logic                     issue_last;

  assign hh_s = signed'({1'b0, geom.hh});
  assign hw_s = signed'({1'b0, geom.hw});

  assign y = mirror(CRD_W'(signed'({1'b0, orow})) + CRD_W'(dy_r), geom.h);
  assign x = mirror(CRD_W'(signed'({1'b0, ocol})) + CRD_W'(dx_r), FH_W'(geom.w));

  assign rd_addr     = {y[RING_W-1:0], x[COL_W-1:0]};
  assign issue_last  = (dy_r == hh_s) && (dx_r == hw_s);
  assign done        = (state_r == ENG_DONE);
  assign busy        = (state_r == ENG_SCAN) || (state_r == ENG_TAIL);
  assign range_value = hi_r - lo_r;

  always_comb begin
    state_nxt = state_r;
    dy_nxt    = dy_r;
    dx_nxt    = dx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    rd_en     = 1'b0;
    if (rd_vld_r) begin
      if (rd_data < lo_r) lo_nxt = rd_data;
      if (rd_data > hi_r) hi_nxt = rd_data;
    end
    unique case (state_r)
      ENG_IDLE, ENG_DONE: begin
        if (start) begin
          state_nxt = ENG_SCAN;
          dy_nxt    = -hh_s;
          dx_nxt    = -hw_s;
          lo_nxt    = '1;
          hi_nxt    = '0;
        end
      end
      ENG_SCAN: begin
        rd_en = 1'b1;
        if (dx_r == hw_s) begin
          dx_nxt = -hw_s;
          dy_nxt = dy_r + 1'b1;
        end else begin
          dx_nxt = dx_r + 1'b1;
        end
        if (issue_last) state_nxt = ENG_TAIL;
      end
      ENG_TAIL: begin
        // The last read lands and is folded this cycle.
        state_nxt = ENG_DONE;
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ENG_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
    dy_r <= dy_nxt;
    dx_r <= dx_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

// ----- hw/rtl/rect_window_gray_range_filter.sv -----
// Streaming gray-range filter (max minus min over a mirrored window): top level.
// Pixels are written into a 32-row line store. Each result is formed by reading its
// N = (2*half_h+1)*(2*half_w+1) window through the store's single read port, one pixel
// a cycle. A pixel is written and checked in a separate state before its first scan;
// a flush with a result pending starts its scan at once, and each further result's scan
// starts as the one before it is registered. A pixel that gives no result, a dropped
// pixel and a flush with nothing pending leave the block idle again. Input is stalled
// until an item's last result is registered, and output stalls lengthen this.
// Up to 16 results follow one pixel; flush transactions drain the rest one each.
// Finished results wait in an output register while the next one is computed.
// The line store needs no clearing after reset.
module rect_window_gray_range_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [rwgrf_pkg::PIX_W-1:0]     in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rwgrf_pkg::PIX_W-1:0]     out_range_value,
  output logic                            out_last_of_run,
  output logic                            out_last_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwgrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwgrf_pkg::FH_W-1:0]      cfg_data
);
  import rwgrf_pkg::*;

  ctl_state_t         state_r, state_nxt;
  logic [FW_W-1:0]    fw_r, fw_nxt;
  logic [FH_W-1:0]    fh_r, fh_nxt;
  logic [MK_W-1:0]    mw_r, mw_nxt, mh_r, mh_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt, cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt, cur_col_r, cur_col_nxt;
  logic               draining_r, draining_nxt;
  logic               fin_done_r, fin_done_nxt;
  logic               flush_mode_r, flush_mode_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_range_r, out_range_nxt;
  logic               out_lor_r, out_lor_nxt, out_lof_r, out_lof_nxt;

  geom_t              geom;
  logic [FW_W-1:0]    w_sat;
  logic [FH_W-1:0]    h_sat;
  logic [MK_W-1:0]    mw_sat, mh_sat;
  logic [HALF_W-1:0]  hw0, hh0;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PIX_W-1:0]   rd_data;
  logic               eng_start, eng_done, eng_busy;
  logic [PIX_W-1:0]   eng_range;

  logic               restart_in;
  logic [ROW_W-1:0]   ir;
  logic [COL_W-1:0]   ic;
  logic               frame_in_done;
  logic               out_free;
  logic               is_last;
  logic [ROW_W-1:0]   next_row;
  logic [COL_W-1:0]   next_col;
  logic               more;

  // Saturated frame sizes and window half sizes.
  always_comb begin
    w_sat  = (fw_r == '0) ? FW_W'(1) : (fw_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_r;
    h_sat  = (fh_r == '0) ? FH_W'(1) : (fh_r > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_r;
    mw_sat = (mw_r == '0) ? MK_W'(1) : (mw_r > MK_W'(MAX_MASK)) ? MK_W'(MAX_MASK) : mw_r;
    mh_sat = (mh_r == '0) ? MK_W'(1) : (mh_r > MK_W'(MAX_MASK)) ? MK_W'(MAX_MASK) : mh_r;
    hw0    = HALF_W'((mw_sat - 1'b1) >> 1);
    hh0    = HALF_W'((mh_sat - 1'b1) >> 1);
    geom.w   = w_sat;
    geom.h   = h_sat;
    geom.wm1 = COL_W'(w_sat - 1'b1);
    geom.hm1 = ROW_W'(h_sat - 1'b1);
    geom.hw  = ((COL_W)'(hw0) > geom.wm1) ? HALF_W'(geom.wm1) : hw0;
    geom.hh  = ((ROW_W)'(hh0) > geom.hm1) ? HALF_W'(geom.hm1) : hh0;
  end

  assign restart_in    = ({1'b0, in_row_r} >= h_sat) || ({1'b0, in_col_r} >= w_sat);
  assign ir            = restart_in ? '0 : in_row_r;
  assign ic            = restart_in ? '0 : in_col_r;
  assign frame_in_done = (ir == geom.hm1) && (ic == geom.wm1);
  assign mem_waddr     = {ir[RING_W-1:0], ic};

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (out_row_r == geom.hm1) && (out_col_r == geom.wm1);
  always_comb begin
    if (is_last) begin
      next_row = '0;
      next_col = '0;
    end else if (out_col_r >= geom.wm1) begin
      next_row = out_row_r + 1'b1;
      next_col = '0;
    end else begin
      next_row = out_row_r;
      next_col = out_col_r + 1'b1;
    end
  end
  assign more = !flush_mode_r && !is_last && (n_r < CNT_W'(RESULT_CAP - 1))
                && win_ready(next_row, next_col, geom, cur_row_r, cur_col_r);

  always_comb begin
    state_nxt      = state_r;
    fw_nxt         = fw_r;
    fh_nxt         = fh_r;
    mw_nxt         = mw_r;
    mh_nxt         = mh_r;
    in_row_nxt     = in_row_r;
    in_col_nxt     = in_col_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    draining_nxt   = draining_r;
    fin_done_nxt   = fin_done_r;
    flush_mode_nxt = flush_mode_r;
    n_nxt          = n_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_range_nxt  = out_range_r;
    out_lor_nxt    = out_lor_r;
    out_lof_nxt    = out_lof_r;
    mem_we         = 1'b0;
    eng_start      = 1'b0;

    unique case (state_r)
      CTL_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_PIXEL) begin
            if (!draining_r) begin
              mem_we         = 1'b1;
              cur_row_nxt    = ir;
              cur_col_nxt    = ic;
              fin_done_nxt   = frame_in_done;
              flush_mode_nxt = 1'b0;
              n_nxt          = '0;
              if (restart_in) begin
                out_row_nxt = '0;
                out_col_nxt = '0;
              end
              if (frame_in_done) begin
                in_row_nxt = '0;
                in_col_nxt = '0;
              end else if (ic == geom.wm1) begin
                in_row_nxt = ir + 1'b1;
                in_col_nxt = '0;
              end else begin
                in_row_nxt = ir;
                in_col_nxt = ic + 1'b1;
              end
              state_nxt = CTL_CHECK;
            end
          end else if (draining_r) begin
            if (({1'b0, out_row_r} >= h_sat) || ({1'b0, out_col_r} >= w_sat)) begin
              in_row_nxt   = '0;
              in_col_nxt   = '0;
              out_row_nxt  = '0;
              out_col_nxt  = '0;
              draining_nxt = 1'b0;
            end else begin
              flush_mode_nxt = 1'b1;
              n_nxt          = '0;
              eng_start      = 1'b1;
              state_nxt      = CTL_BUSY;
            end
          end
        end
      end
      CTL_CHECK: begin
        if (win_ready(out_row_r, out_col_r, geom, cur_row_r, cur_col_r)) begin
          eng_start = 1'b1;
          state_nxt = CTL_BUSY;
        end else begin
          if (fin_done_r) draining_nxt = 1'b1;
          state_nxt = CTL_IDLE;
        end
      end
      CTL_BUSY: begin
        if (eng_done && out_free) begin
          out_valid_nxt = 1'b1;
          out_range_nxt = eng_range;
          out_lof_nxt   = is_last;
          out_lor_nxt   = !more;
          out_row_nxt   = next_row;
          out_col_nxt   = next_col;
          n_nxt         = n_r + 1'b1;
          if (more) begin
            eng_start = 1'b1;
          end else begin
            state_nxt = CTL_IDLE;
            if (flush_mode_r) begin
              if (is_last) draining_nxt = 1'b0;
            end else if (fin_done_r) begin
              draining_nxt = !is_last;
            end
          end
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase

    // Any register write restarts the stream.
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  fw_nxt = cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_nxt = cfg_data;
        CFG_MASK_WIDTH:   mw_nxt = cfg_data[MK_W-1:0];
        CFG_MASK_HEIGHT:  mh_nxt = cfg_data[MK_W-1:0];
        default:          fw_nxt = fw_r;
      endcase
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      draining_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      fw_r        <= FW_W'(64);
      fh_r        <= FH_W'(64);
      mw_r        <= MK_W'(3);
      mh_r        <= MK_W'(3);
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      draining_r  <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      mw_r        <= mw_nxt;
      mh_r        <= mh_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      draining_r  <= draining_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_row_r    <= cur_row_nxt;
    cur_col_r    <= cur_col_nxt;
    fin_done_r   <= fin_done_nxt;
    flush_mode_r <= flush_mode_nxt;
    out_range_r  <= out_range_nxt;
    out_lor_r    <= out_lor_nxt;
    out_lof_r    <= out_lof_nxt;
  end

  rwgrf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_pixel),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rwgrf_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (eng_start),
    .geom        (geom),
    .orow        (out_row_r),
    .ocol        (out_col_r),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .done        (eng_done),
    .busy        (eng_busy),
    .range_value (eng_range)
  );

  assign in_stall          = (state_r != CTL_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_range_value   = out_range_r;
  assign out_last_of_run   = out_lor_r;
  assign out_last_of_frame = out_lof_r;

`ifndef SYNTH
  a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !eng_busy) else $error("scanner busy while input is open");
  a_frame_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lof_r |-> out_lor_r) else $error("frame end not marked end of run");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(RESULT_CAP)) else $error("result count over cap");
  a_drain_input_home: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (in_row_r == '0) && (in_col_r == '0))
    else $error("draining with input position not at frame start");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the streaming gray-range filter.
`timescale 1ns / 1ps

module testbench;
  import rwgrf_pkg::*;

  localparam int RING  = 32;
  localparam int LIMIT = 4000000;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] pix;
  } pixel_item_t;

  typedef struct {
    logic [7:0] rng;
    logic       last_run;
    logic       last_frame;
  } range_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [7:0] in_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_range_value;
  logic out_last_of_run;
  logic out_last_of_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FH_W-1:0] cfg_data = '0;

  rect_window_gray_range_filter uut (.*);

  // Model state of the filter.
  logic [7:0] line_mem [0:RING*MAX_WIDTH-1];
  int frame_w = 64, frame_h = 64, mask_w = 3, mask_h = 3;
  int in_r, in_c, out_r, out_c;
  bit drain_pending;

  pixel_item_t   pend_q[$];
  range_result_t range_q[$];
  int  errors;
  int  cycles;
  int  queued;
  bit  send_gaps = 1'b1;
  bit  recv_stalls = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int half_size(int m, int n);
    int h;
    h = (clip(m, 1, MAX_MASK) - 1) / 2;
    return (h > n - 1) ? n - 1 : h;
  endfunction

  function automatic int reflect101(int v, int n);
    if (v < 0) v = -v;
    if (v >= n) v = 2 * n - 2 - v;
    return (v < 0) ? 0 : v;
  endfunction

  function automatic logic [7:0] window_range(int r, int c, int w, int h, int hw, int hh);
    int lo, hi, y, x, v;
    lo = 255;
    hi = 0;
    for (int dy = -hh; dy <= hh; dy++) begin
      y = reflect101(r + dy, h);
      for (int dx = -hw; dx <= hw; dx++) begin
        x = reflect101(c + dx, w);
        v = line_mem[(y % RING) * MAX_WIDTH + x];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    end
    return 8'(hi - lo);
  endfunction

  function automatic void restart_stream();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    drain_pending = 1'b0;
  endfunction

  // Queues the result for the current output position and advances it.
  function automatic bit push_result(int w, int h, int hw, int hh);
    range_result_t e;
    bit last;
    last = (out_r == h - 1) && (out_c == w - 1);
    e.rng = window_range(out_r, out_c, w, h, hw, hh);
    e.last_run = 1'b0;
    e.last_frame = last;
    range_q = {range_q, e};
    if (last) begin
      out_r = 0;
      out_c = 0;
    end else if (out_c + 1 >= w) begin
      out_c = 0;
      out_r++;
    end else begin
      out_c++;
    end
    return last;
  endfunction

  function automatic void predict_ranges(cmd_t cmd, logic [7:0] pix);
    int w, h, hw, hh, n, ir, ic, lr, lc;
    bit in_done, out_done;
    w = clip(frame_w, 1, MAX_WIDTH);
    h = clip(frame_h, 1, MAX_HEIGHT);
    hw = half_size(mask_w, w);
    hh = half_size(mask_h, h);
    n = 0;
    out_done = 1'b0;
    if (cmd == CMD_PIXEL) begin
      if (drain_pending) return;
      if (in_r >= h || in_c >= w) restart_stream();
      ir = in_r;
      ic = in_c;
      line_mem[(ir % RING) * MAX_WIDTH + ic] = pix;
      in_done = (ir == h - 1) && (ic == w - 1);
      if (ic + 1 >= w) begin
        in_c = 0;
        in_r = ir + 1;
      end else begin
        in_c = ic + 1;
      end
      while (n < RESULT_CAP) begin
        lr = (out_r + hh > h - 1) ? h - 1 : out_r + hh;
        lc = (out_c + hw > w - 1) ? w - 1 : out_c + hw;
        if (!(lr < ir || (lr == ir && lc <= ic))) break;
        out_done = push_result(w, h, hw, hh);
        n++;
        if (out_done) break;
      end
      if (in_done) begin
        in_r = 0;
        in_c = 0;
        drain_pending = !out_done;
      end
    end else begin
      if (!drain_pending) return;
      if (out_r >= h || out_c >= w) begin
        restart_stream();
        return;
      end
      if (push_result(w, h, hw, hh)) drain_pending = 1'b0;
      n = 1;
    end
    if (n > 0) range_q[range_q.size() - 1].last_run = 1'b1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("ERROR at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Driver: one pixel or flush transaction per handshake, random gaps between them when send_gaps is set.
  int gap_left;
  always @(posedge clk) begin
    bit nv;
    pixel_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        predict_ranges(cmd_t'(in_command), in_pixel);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          it = pend_q.pop_front();
          in_command <= it.cmd;
          in_pixel <= it.pix;
          nv = 1'b1;
          gap_left = send_gaps ? $urandom_range(0, 7) : 0;
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor: checks each accepted result and draws the next receive stall.
  int stall_left;
  always @(posedge clk) begin
    range_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (range_q.size() == 0) begin
          report("unexpected result, range", out_range_value, 0);
        end else begin
          e = range_q.pop_front();
          if (out_range_value !== e.rng) report("range_value", out_range_value, e.rng);
          if (out_last_of_run !== e.last_run)
            report("last_of_run", out_last_of_run, e.last_run);
          if (out_last_of_frame !== e.last_frame)
            report("last_of_frame", out_last_of_frame, e.last_frame);
        end
        stall_left = recv_stalls ? $urandom_range(0, 7) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= FH_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = val & 12'hFFF;
      CFG_FRAME_HEIGHT: frame_h = val & 13'h1FFF;
      CFG_MASK_WIDTH:   mask_w = val & 5'h1F;
      CFG_MASK_HEIGHT:  mask_h = val & 5'h1F;
    endcase
    restart_stream();
  endtask

  // Holds off until every queued transaction is sent and every result is back.
  // Sampled at the falling edge so the driver's updates of the rising edge are seen.
  task automatic wait_drained();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || range_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int mw, int mh);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_MASK_WIDTH, mw);
    write_reg(CFG_MASK_HEIGHT, mh);
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_stalls = ($urandom_range(0, 3) != 0);
  endtask

  task automatic queue_item(cmd_t cmd, int pix);
    pixel_item_t it;
    it.cmd = cmd;
    it.pix = 8'(pix);
    pend_q = {pend_q, it};
    queued++;
  endtask

  // One frame of random pixels, then the given number of flushes, with some noise.
  task automatic queue_frame(int npix, int nflush, int style);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 11) == 0) queue_item(CMD_FLUSH, $urandom_range(0, 255));
      case (style)
        0: queue_item(CMD_PIXEL, $urandom_range(0, 255));
        1: queue_item(CMD_PIXEL, (base + $urandom_range(0, 15)) & 8'hFF);
        default: queue_item(CMD_PIXEL, $urandom_range(0, 1) ? 255 : 0);
      endcase
    end
    for (int i = 0; i < nflush; i++) begin
      if ($urandom_range(0, 15) == 0) queue_item(CMD_PIXEL, $urandom_range(0, 255));
      queue_item(CMD_FLUSH, $urandom_range(0, 255));
    end
  endtask

  initial begin
    int w, h, mw, mh;
    for (int i = 0; i < RING * MAX_WIDTH; i++) line_mem[i] = '0;
    restart_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of pixel values, flush before any pixel, small frame.
    configure(6, 4, 3, 3);
    queue_item(CMD_FLUSH, 8'hFF);
    queue_item(CMD_PIXEL, 0);
    queue_item(CMD_PIXEL, 255);
    for (int i = 0; i < 22; i++) queue_item(CMD_PIXEL, (i & 1) ? 8'hAA : 8'h55);
    for (int i = 0; i < 4; i++) queue_item(CMD_FLUSH, 0);

    // Mask larger than the frame in either direction; all results wait for the last pixel.
    configure(10, 2, 31, 31);
    queue_frame(20, 6, 0);
    configure(2, 10, 31, 31);
    queue_frame(20, 6, 0);
    // Zero sizes saturate to one; one-pixel frame.
    configure(0, 0, 0, 0);
    queue_frame(3, 3, 0);
    // Oversized width saturates to the maximum; even masks; partial frame.
    configure(4095, 1, 2, 4);
    queue_frame(20, 2, 1);
    // Oversized height saturates, single column.
    configure(1, 8191, 30, 1);
    queue_frame(12, 2, 2);
    configure(5, 5, 4, 6);
    queue_frame(25, 4, 1);

    while (queued < 280) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      mw = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      mh = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      configure(w, h, mw, mh);
      queue_frame(w * h, w * h + 2, $urandom_range(0, 2));
    end

    wait_drained();
    repeat (2000) @(posedge clk);
    while (range_q.size() > 0) begin
      report("missing result, range", -1, range_q[0].rng);
      void'(range_q.pop_front());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- rect_window_gray_range_filter.f -----
hw/rtl/rwgrf_pkg.sv
hw/rtl/rwgrf_ram.sv
hw/rtl/rwgrf_scan.sv
hw/rtl/rect_window_gray_range_filter.sv
tb/testbench.sv
